FILE: rtl/assert_macros.svh
// Assertion macros used by the fixed-point ALU.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define FPA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fixed-point ALU assertion failed");

// Implication with a constant delay in cycles.
`define FPA_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error("fixed-point ALU assertion failed");

`endif

FILE: rtl/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Operation codes, word types and pipeline control shared by the ALU sources.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned WordW        = 32;
  localparam int unsigned FracBitsDflt = 8;

  typedef enum logic [3:0] {
    KIND_ADD      = 4'd0,
    KIND_SUB      = 4'd1,
    KIND_MUL      = 4'd2,
    KIND_DIV      = 4'd3,
    KIND_GT       = 4'd4,
    KIND_LT       = 4'd5,
    KIND_GE       = 4'd6,
    KIND_LE       = 4'd7,
    KIND_EQ       = 4'd8,
    KIND_NE       = 4'd9,
    KIND_MIN      = 4'd10,
    KIND_MAX      = 4'd11,
    KIND_INC      = 4'd12,
    KIND_DEC      = 4'd13,
    KIND_FROM_INT = 4'd14,
    KIND_TO_INT   = 4'd15
  } fpa_kind_e;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_in_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
  } fpa_out_t;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic neg;
    logic dz;
    logic cmp;
  } fpa_ctrl_t;

endpackage

FILE: rtl/fpa_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU divider cell
// One restoring division step per cell; the word and its side results ride along.
// ----------------------------------------------------------------------------
module fpa_div_cell
  import fpa_pkg::*;
#(
  parameter int unsigned DivW = 40
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpa_ctrl_t         ctrl_i,
  input  logic [WordW-1:0]  value_i,
  input  logic [WordW-1:0]  divisor_i,
  input  logic [WordW-1:0]  rem_i,
  input  logic [DivW-1:0]   dq_i,
  output fpa_ctrl_t         ctrl_o,
  output logic [WordW-1:0]  value_o,
  output logic [WordW-1:0]  divisor_o,
  output logic [WordW-1:0]  rem_o,
  output logic [DivW-1:0]   dq_o
);

  logic [WordW:0]   shifted;
  logic             fits;
  logic [WordW:0]   diff;
  logic [WordW-1:0] rem_d, rem_q, value_q, divisor_q;
  logic [DivW-1:0]  dq_d, dq_q;
  fpa_ctrl_t        ctrl_q;

  assign shifted = {rem_i, dq_i[DivW-1]};
  assign fits    = shifted >= {1'b0, divisor_i};
  assign diff    = shifted - {1'b0, divisor_i};
  assign rem_d   = fits ? diff[WordW-1:0] : shifted[WordW-1:0];
  assign dq_d    = {dq_i[DivW-2:0], fits};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q   <= value_i;
    divisor_q <= divisor_i;
    rem_q     <= rem_d;
    dq_q      <= dq_d;
  end

  assign ctrl_o    = ctrl_q;
  assign value_o   = value_q;
  assign divisor_o = divisor_q;
  assign rem_o     = rem_q;
  assign dq_o      = dq_q;

endmodule

FILE: rtl/fixed_point_alu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed 32-bit fixed-point arithmetic unit, fully pipelined.
// ----------------------------------------------------------------------------
// A word is taken on req_i at every rising edge where start is high; busy
// is tied low, so a new word may be issued in every cycle.
// Each word yields exactly one result word on res_o, marked by done_o for a
// single cycle. done_o rises once the word has passed the input stage, the
// divider cell row and the output register, and the result is taken at the
// edge after done_o rises. Throughput is one word per cycle. The divider is a
// row of 32 + FracBits identical cells that each resolve one quotient bit; every
// operation travels through that row so results leave in issue order.
// The multiplier takes the first stage, its rounding toward zero happens as
// the word enters the cell row, and the quotient sign is applied in the
// output register.
// Reset clears all valid flags; words in flight are dropped. The receiver
// cannot stall: a result must be taken in the cycle done_o is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fixed_point_alu
  import fpa_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDflt
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  fpa_in_t  req_i,
  output logic     done_o,
  output fpa_out_t res_o
);

  localparam int unsigned DivW = WordW + FracBits;
  localparam int unsigned Lat  = DivW + 2;

  fpa_kind_e          kind;
  logic signed [31:0] a, b;
  logic [WordW-1:0]   mag_a, mag_b;
  logic [WordW-1:0]   other_d;
  logic               cmp_d;
  logic               accept;

  fpa_ctrl_t           s0_ctrl_q;
  logic                s0_is_mul_q;
  logic signed [63:0]  s0_prod_q;
  logic [WordW-1:0]    s0_other_q, s0_div_q;
  logic [DivW-1:0]     s0_dq_q;
  logic signed [63:0]  prod_bias;
  logic [WordW-1:0]    entry_value;

  fpa_ctrl_t        ctrl_w    [DivW+1];
  logic [WordW-1:0] value_w   [DivW+1];
  logic [WordW-1:0] divisor_w [DivW+1];
  logic [WordW-1:0] rem_w     [DivW+1];
  logic [DivW-1:0]  dq_w      [DivW+1];

  fpa_ctrl_t        out_ctrl;
  logic [WordW-1:0] quot;
  logic [WordW-1:0] out_value;
  logic             done_q;
  fpa_out_t         res_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign kind   = fpa_kind_e'(req_i.kind);
  assign a      = req_i.operand_a;
  assign b      = req_i.operand_b;
  assign mag_a  = a[31] ? (~a + 32'd1) : a;
  assign mag_b  = b[31] ? (~b + 32'd1) : b;

  always_comb begin
    other_d = '0;
    cmp_d   = 1'b0;
    unique case (kind)
      KIND_ADD:      other_d = a + b;
      KIND_SUB:      other_d = a - b;
      KIND_GT:       cmp_d = a > b;
      KIND_LT:       cmp_d = a < b;
      KIND_GE:       cmp_d = a >= b;
      KIND_LE:       cmp_d = a <= b;
      KIND_EQ:       cmp_d = a == b;
      KIND_NE:       cmp_d = a != b;
      KIND_MIN:      other_d = (a < b) ? a : b;
      KIND_MAX:      other_d = (a > b) ? a : b;
      KIND_INC:      other_d = a + 32'sd1;
      KIND_DEC:      other_d = a - 32'sd1;
      KIND_FROM_INT: other_d = a << FracBits;
      KIND_TO_INT:   other_d = a >>> FracBits;
      default:       other_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_ctrl_q <= '0;
    end else begin
      s0_ctrl_q.valid  <= accept;
      s0_ctrl_q.is_div <= (kind == KIND_DIV);
      s0_ctrl_q.neg    <= a[31] ^ b[31];
      s0_ctrl_q.dz     <= (kind == KIND_DIV) && (b == 32'sd0);
      s0_ctrl_q.cmp    <= cmp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_is_mul_q <= (kind == KIND_MUL);
    s0_prod_q   <= 64'(a) * 64'(b);
    s0_other_q  <= other_d;
    s0_div_q    <= mag_b;
    s0_dq_q     <= {mag_a, {FracBits{1'b0}}};
  end

  assign prod_bias   = s0_prod_q[63]
                       ? s0_prod_q + 64'((64'd1 << FracBits) - 64'd1) : s0_prod_q;
  assign entry_value = s0_is_mul_q ? WordW'(prod_bias >>> FracBits) : s0_other_q;

  assign ctrl_w[0]    = s0_ctrl_q;
  assign value_w[0]   = entry_value;
  assign divisor_w[0] = s0_div_q;
  assign rem_w[0]     = '0;
  assign dq_w[0]      = s0_dq_q;

  for (genvar gi = 0; gi < DivW; gi++) begin : g_cell
    fpa_div_cell #(
      .DivW(DivW)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_w[gi]),
      .value_i   (value_w[gi]),
      .divisor_i (divisor_w[gi]),
      .rem_i     (rem_w[gi]),
      .dq_i      (dq_w[gi]),
      .ctrl_o    (ctrl_w[gi+1]),
      .value_o   (value_w[gi+1]),
      .divisor_o (divisor_w[gi+1]),
      .rem_o     (rem_w[gi+1]),
      .dq_o      (dq_w[gi+1])
    );
  end

  assign out_ctrl = ctrl_w[DivW];
  assign quot     = dq_w[DivW][WordW-1:0];

  always_comb begin
    if (!out_ctrl.is_div) begin
      out_value = value_w[DivW];
    end else if (out_ctrl.dz) begin
      out_value = '0;
    end else begin
      out_value = out_ctrl.neg ? (~quot + 32'd1) : quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= out_ctrl.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.result_value   <= out_value;
    res_q.compare_true   <= out_ctrl.cmp;
    res_q.divide_by_zero <= out_ctrl.dz;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `FPA_ASSERT_DELAY(a_issue_to_done, accept, Lat, done_o)
  `FPA_ASSERT_IMPL(a_dz_zero, done_o && res_o.divide_by_zero, res_o.result_value == 32'sd0)
  `FPA_ASSERT_IMPL(a_cmp_zero, done_o && res_o.compare_true, res_o.result_value == 32'sd0)
  `FPA_ASSERT_IMPL(a_flags_excl, done_o, !(res_o.compare_true && res_o.divide_by_zero))

endmodule

FILE: tb/fixed_point_alu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU checker
// Watches the command and result channels, predicts each result word from
// the accepted command word and compares the two as whole words, in order.
// ----------------------------------------------------------------------------
module fixed_point_alu_checker
  import fpa_pkg::*;
#(
  parameter int unsigned FracBits = FracBitsDflt
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  logic     busy_i,
  input  fpa_in_t  req_i,
  input  logic     done_i,
  input  fpa_out_t res_i,
  output int       errors_o,
  output int       pending_o
);

  fpa_out_t expected_q[$];

  function automatic fpa_out_t alu_predict(fpa_in_t w);
    fpa_out_t r;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] t;
    a = w.operand_a;
    b = w.operand_b;
    r = '0;
    case (fpa_kind_e'(w.kind))
      KIND_ADD: r.result_value = w.operand_a + w.operand_b;
      KIND_SUB: r.result_value = w.operand_a - w.operand_b;
      KIND_MUL: begin
        t = (a * b) / (64'sd1 <<< FracBits);
        r.result_value = t[31:0];
      end
      KIND_DIV: begin
        if (b == 0) begin
          r.divide_by_zero = 1'b1;
        end else begin
          t = (a <<< FracBits) / b;
          r.result_value = t[31:0];
        end
      end
      KIND_GT: r.compare_true = a > b;
      KIND_LT: r.compare_true = a < b;
      KIND_GE: r.compare_true = a >= b;
      KIND_LE: r.compare_true = a <= b;
      KIND_EQ: r.compare_true = a == b;
      KIND_NE: r.compare_true = a != b;
      KIND_MIN: r.result_value = (a < b) ? w.operand_a : w.operand_b;
      KIND_MAX: r.result_value = (a > b) ? w.operand_a : w.operand_b;
      KIND_INC: r.result_value = w.operand_a + 32'sd1;
      KIND_DEC: r.result_value = w.operand_a - 32'sd1;
      KIND_FROM_INT: r.result_value = w.operand_a <<< FracBits;
      default: r.result_value = w.operand_a >>> FracBits;
    endcase
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always_ff @(posedge clk_i or negedge rst_ni) begin
    fpa_out_t e;
    if (!rst_ni) begin
      errors_o <= 0;
    end else begin
      if (start_i && !busy_i) begin
        expected_q.push_back(alu_predict(req_i));
      end
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word %h", $realtime, res_i);
          errors_o <= errors_o + 1;
        end else begin
          e = expected_q.pop_front();
          if (e !== res_i) begin
            $display("%0t: expected %h/%b/%b actual %h/%b/%b", $realtime,
                     e.result_value, e.compare_true, e.divide_by_zero,
                     res_i.result_value, res_i.compare_true, res_i.divide_by_zero);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

FILE: tb/fixed_point_alu_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU testbench
// Drives directed corner words and then random words, with random gaps and
// back-to-back bursts, into the ALU; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int Latency = FracBitsDflt + 34;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  fpa_in_t  req = '0;
  logic     done;
  fpa_out_t res;
  int       errors;
  int       pending;

  always #5 clk_i = ~clk_i;

  fixed_point_alu uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .req_i(req), .done_o(done), .res_o(res)
  );

  fixed_point_alu_checker chk (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start), .busy_i(busy), .req_i(req),
    .done_i(done), .res_i(res), .errors_o(errors), .pending_o(pending)
  );

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'(signed'($urandom_range(0, 2000)) - 1000);
      5: return 32'($urandom_range(0, 511)) << 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(fpa_kind_e k, logic [31:0] a, logic [31:0] b);
    int gap;
    req   <= '{kind: k, operand_a: a, operand_b: b};
    start <= 1'b1;
    do @(posedge clk_i); while (busy);
    if ($urandom_range(0, 2) != 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(1, 3);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [31:0] edges[4];
    int burst;
    edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int k = 0; k < 16; k++) begin
      send_word(fpa_kind_e'(k), edges[k % 4], edges[(k + 1) % 4]);
    end
    send_word(KIND_DIV, 32'h0000_0100, 32'h0);
    send_word(KIND_DIV, 32'h8000_0000, 32'hFFFF_FF00);
    send_word(KIND_MUL, 32'h8000_0000, 32'h8000_0000);
    send_word(KIND_MUL, 32'hFFFF_FFFF, 32'h0000_0001);
    send_word(KIND_EQ, 32'h1234_5678, 32'h1234_5678);
    send_word(KIND_MIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_word(KIND_TO_INT, 32'hFFFF_FF01, 32'h0);
    drain();
    for (int i = 0; i < 880; i++) begin
      send_word(fpa_kind_e'($urandom_range(0, 15)), pick_operand(), pick_operand());
      if (i == 440) drain();
      if ($urandom_range(0, 99) == 0) begin
        burst = $urandom_range(20, 60);
        repeat (burst) begin
          req   <= '{kind: 4'($urandom_range(0, 15)), operand_a: $urandom(),
                     operand_b: $urandom()};
          start <= 1'b1;
          do @(posedge clk_i); while (busy);
        end
      end
    end
    drain();
    repeat (Latency + 10) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS fixed_point_alu");
    end else begin
      $display("FAIL fixed_point_alu");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL fixed_point_alu");
    $finish;
  end

endmodule
